// ===== src/etss_pkg.sv =====
// ---------------------------------------------------------------------------
// etss_pkg
// Types, constants and helper functions for the echo-to-distance display.
// ---------------------------------------------------------------------------
`default_nettype none

package etss_pkg;

	localparam int unsigned REM_W  = 40;	// holds 10000 * largest divisor
	localparam int unsigned Q_W    = 14;	// quotient below 10000
	localparam int unsigned BCD_W  = 16;
	localparam int unsigned SCALE_W = 16;

	localparam logic [SCALE_W-1:0] SCALE_NUM  = 16'd34029;
	localparam logic [31:0]        ERROR_WORD = 32'h86AF2FFF;
	localparam logic [Q_W-1:0]     RANGE_LIMIT = 14'd10000;
	localparam logic [11:0]        BAR_TOP    = 12'hFFF;

	// Divisor selection: {metre_units, fine_point}
	typedef enum logic [1:0] {
		MODE_PLAIN = 2'b00,
		MODE_FINE  = 2'b01,
		MODE_METRE = 2'b10,
		MODE_BOTH  = 2'b11
	} mode_t;

	typedef logic [3:0][REM_W-1:0]        den_tab_t;
	typedef logic [3:0][10:1][REM_W-1:0]  thr_tab_t;

	// Sideband carried along the divider and digit stages
	typedef struct packed {
		mode_t       mode;
		logic        over;
		logic        bar_wr;
		logic [11:0] bar_pat;
	} side_t;

	typedef struct packed {
		logic [REM_W-1:0] rem;
		logic [Q_W-1:0]   q;
	} div_t;

	function automatic den_tab_t make_den();
		den_tab_t t;
		t[MODE_PLAIN] = REM_W'(64'd100000);
		t[MODE_FINE]  = REM_W'(64'd1000000);
		t[MODE_METRE] = REM_W'(64'd10000000);
		t[MODE_BOTH]  = REM_W'(64'd100000000);
		return t;
	endfunction

	localparam den_tab_t DEN_TAB = make_den();

	// 1000 * k * divisor for each mode; step ten is the range limit
	function automatic thr_tab_t make_thr();
		thr_tab_t t;
		logic [63:0] d;
		for (int m = 0; m < 4; m++) begin
			d = 64'(DEN_TAB[m]);
			for (int k = 1; k <= 10; k++) begin
				t[m][k] = REM_W'(d * 64'd1000 * 64'(k));
			end
		end
		return t;
	endfunction

	localparam thr_tab_t THR_TAB = make_thr();

	// Restoring division: n quotient bits starting at bit position top
	function automatic div_t div_steps(input div_t in, input logic [REM_W-1:0] den,
			input int top, input int n);
		div_t             d;
		logic [REM_W-1:0] trial;
		d = in;
		for (int j = 0; j < n; j++) begin
			trial = den << (top - j);
			if (d.rem >= trial) begin
				d.rem = d.rem - trial;
				d.q[top - j] = 1'b1;
			end
		end
		return d;
	endfunction

	// Seven shift-and-add-3 steps of binary to BCD
	function automatic logic [BCD_W-1:0] dd_steps(input logic [BCD_W-1:0] bcd_in,
			input logic [6:0] bits);
		logic [BCD_W-1:0] b;
		b = bcd_in;
		for (int i = 6; i >= 0; i--) begin
			for (int g = 0; g < 4; g++) begin
				if (b[g*4 +: 4] >= 4'd5)
					b[g*4 +: 4] = b[g*4 +: 4] + 4'd3;
			end
			b = {b[BCD_W-2:0], bits[i]};
		end
		return b;
	endfunction

	function automatic logic [7:0] seg_code(input logic [3:0] digit);
		logic [7:0] s;
		unique case (digit)
			4'd0: s = 8'hC0;
			4'd1: s = 8'hF9;
			4'd2: s = 8'hA4;
			4'd3: s = 8'hB0;
			4'd4: s = 8'h99;
			4'd5: s = 8'h92;
			4'd6: s = 8'h82;
			4'd7: s = 8'hF8;
			4'd8: s = 8'h80;
			4'd9: s = 8'h98;
			default: s = 8'hFF;
		endcase
		return s;
	endfunction

endpackage

`default_nettype wire

// ===== src/echo_ticks_to_seven_segment_top.sv =====
// ---------------------------------------------------------------------------
// echo_ticks_to_seven_segment_top
// Echo length in timer ticks to a four-digit seven-segment distance display.
// ---------------------------------------------------------------------------
// Usage:
//   Drive echo_ticks, metre_units, fine_point and bar_enable and pulse start.
//   busy is held low, so a transfer is taken on every cycle with start high;
//   a new echo length may follow in the very next cycle.
//   Each transfer yields one result: done is high for one cycle with
//   display_word, out_of_range, distance_value, bar_write and bar_pattern.
//   Throughput is one item per cycle. The eight stages are the
//   scaling multiplier, the threshold compares, four stages of the 14-bit
//   restoring divider, and two stages of binary to BCD with segment encode.
//   The receiver cannot stall: every result is presented exactly once.
//   Reset clears every valid bit, so no result appears until fed again;
//   payload registers keep whatever they held.
// ---------------------------------------------------------------------------
`default_nettype none

module echo_ticks_to_seven_segment_top
	import etss_pkg::*;
#(
	parameter int unsigned TICK_BITS = 24
) (
	input  wire logic                 clk,
	input  wire logic                 arst_n,
	input  wire logic                 start,
	output logic                      busy,
	input  wire logic [TICK_BITS-1:0] echo_ticks,
	input  wire logic                 metre_units,
	input  wire logic                 fine_point,
	input  wire logic                 bar_enable,
	output logic                      done,
	output logic [31:0]               display_word,
	output logic                      out_of_range,
	output logic [13:0]               distance_value,
	output logic                      bar_write,
	output logic [11:0]               bar_pattern
);

	// Scaled numerator width and the width both sides of a compare share
	localparam int unsigned NUM_W = TICK_BITS + SCALE_W;
	localparam int unsigned CMP_W = (NUM_W > REM_W) ? NUM_W : REM_W;

	// The pipeline never stalls, so a transfer is possible every cycle
	assign busy = 1'b0;

	logic accept;
	assign accept = start & ~busy;

	// Valid bits, one per stage
	logic v_s1, v_s2, v_s3, v_s4, v_s5, v_s6, v_s7;

	// Stage 1: scale the tick count
	logic [NUM_W-1:0] num_s1;
	mode_t            mode_s1;
	logic             bar_en_s1;

	// Stage 2 onwards: remainder, partial quotient and sideband
	logic [REM_W-1:0] rem_s2;
	side_t            side_s2, side_s3, side_s4, side_s5, side_s6, side_s7;
	div_t             div_s3, div_s4, div_s5, div_s6;
	logic [BCD_W-1:0] bcd_s7;
	logic [6:0]       qlo_s7;
	logic [6:0]       qhi_s7;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
			v_s3 <= 1'b0;
			v_s4 <= 1'b0;
			v_s5 <= 1'b0;
			v_s6 <= 1'b0;
			v_s7 <= 1'b0;
			done <= 1'b0;
		end else begin
			v_s1 <= accept;
			v_s2 <= v_s1;
			v_s3 <= v_s2;
			v_s4 <= v_s3;
			v_s5 <= v_s4;
			v_s6 <= v_s5;
			v_s7 <= v_s6;
			done <= v_s7;
		end
	end

	// Stage 1: multiply by the speed-of-sound scale numerator
	always_ff @(posedge clk) begin
		num_s1    <= NUM_W'(echo_ticks) * NUM_W'(SCALE_NUM);
		mode_s1   <= mode_t'({metre_units, fine_point});
		bar_en_s1 <= bar_enable;
	end

	// Stage 2: compare against the bar thresholds and the range limit.
	// The thresholds rise with k, so the exceeded set is already a
	// thermometer code; the top step lights the whole bar.
	logic [CMP_W-1:0] num_ext;
	logic [9:1]       above;
	logic             over_c;
	logic [11:0]      thermo;
	side_t            side_c;

	always_comb begin
		num_ext = CMP_W'(num_s1);
		for (int k = 1; k <= 9; k++) begin
			above[k] = num_ext > CMP_W'(THR_TAB[mode_s1][k]);
		end
		over_c = num_ext >= CMP_W'(THR_TAB[mode_s1][10]);
		thermo = {{4{above[9]}}, above[8:1]};

		side_c.mode    = mode_s1;
		side_c.over    = over_c;
		side_c.bar_wr  = ~(bar_en_s1 & over_c);
		side_c.bar_pat = (bar_en_s1 & ~over_c) ? thermo : 12'h000;
	end

	always_ff @(posedge clk) begin
		// Drop the numerator when out of range so the divider stays in bounds
		rem_s2  <= over_c ? '0 : num_ext[REM_W-1:0];
		side_s2 <= side_c;
	end

	// Stages 3 to 6: restoring division by the selected divisor,
	// four quotient bits per stage, then the last two
	div_t div_in;
	assign div_in = '{rem: rem_s2, q: '0};

	always_ff @(posedge clk) begin
		div_s3  <= div_steps(div_in, DEN_TAB[side_s2.mode], 13, 4);
		side_s3 <= side_s2;
		div_s4  <= div_steps(div_s3, DEN_TAB[side_s3.mode], 9, 4);
		side_s4 <= side_s3;
		div_s5  <= div_steps(div_s4, DEN_TAB[side_s4.mode], 5, 4);
		side_s5 <= side_s4;
		div_s6  <= div_steps(div_s5, DEN_TAB[side_s5.mode], 1, 2);
		side_s6 <= side_s5;
	end

	// Stage 7: first half of binary to BCD on the upper quotient bits;
	// hold the binary quotient alongside for the distance output
	always_ff @(posedge clk) begin
		bcd_s7  <= dd_steps('0, div_s6.q[13:7]);
		qhi_s7  <= div_s6.q[13:7];
		qlo_s7  <= div_s6.q[6:0];
		side_s7 <= side_s6;
	end

	// Stage 8: finish BCD, encode segments and place the point
	logic [BCD_W-1:0] bcd_c;
	logic [7:0]       seg3, seg2, seg1, seg0;
	logic [31:0]      word_c;
	logic             fine_c;

	always_comb begin
		bcd_c  = dd_steps(bcd_s7, qlo_s7);
		fine_c = side_s7.mode[0];
		seg3   = seg_code(bcd_c[15:12]);
		seg2   = seg_code(bcd_c[11:8]);
		seg1   = seg_code(bcd_c[7:4]);
		seg0   = seg_code(bcd_c[3:0]);
		if (fine_c) begin
			seg2[7] = 1'b0;
		end else begin
			seg3[7] = 1'b0;
		end
		word_c = side_s7.over ? ERROR_WORD : {seg3, seg2, seg1, seg0};
	end

	always_ff @(posedge clk) begin
		display_word   <= word_c;
		out_of_range   <= side_s7.over;
		distance_value <= side_s7.over ? RANGE_LIMIT : {qhi_s7, qlo_s7};
		bar_write      <= side_s7.bar_wr;
		bar_pattern    <= side_s7.bar_pat;
	end

endmodule

`default_nettype wire

// ===== bench/echo_ticks_to_seven_segment_top_tb.sv =====
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// echo_ticks_to_seven_segment_top_tb
// Self-checking bench for the echo length to seven-segment distance display.
// Directed echo lengths hit zero, full scale, every divisor mode, every digit
// code, both point positions and the edges of the bar steps and the range
// limit. Random echo lengths follow, with random gaps on the command side. An
// in-bench calculation of the exact rational distance predicts each reading,
// and every done strobe is checked against the oldest prediction.
// ---------------------------------------------------------------------------

module echo_ticks_to_seven_segment_top_tb
	import etss_pkg::*;
;

	localparam int unsigned TICK_BITS    = 24;
	localparam int unsigned RANDOM_ITEMS = 500;
	localparam int unsigned CALM_ITEMS   = 60;	// closing stretch with no gaps
	localparam int unsigned DRAIN_CYCLES = 16;	// idle wait for stray strobes after draining
	localparam int unsigned LIMIT_CYCLES = 200000;

	localparam longint unsigned SCALE     = 64'd34029;
	localparam longint unsigned TICKS_MAX = (64'd1 << TICK_BITS) - 1;

	localparam logic [7:0] DIGIT_SEG [10] = '{
		8'hC0, 8'hF9, 8'hA4, 8'hB0, 8'h99, 8'h92, 8'h82, 8'hF8, 8'h80, 8'h98
	};

	typedef struct packed {
		logic [31:0] word;
		logic        over;
		logic [13:0] distance;
		logic        bar_wr;
		logic [11:0] bar_pat;
	} reading_t;

	logic                 clk;
	logic                 arst_n;
	logic                 start;
	logic                 busy;
	logic [TICK_BITS-1:0] echo_ticks;
	logic                 metre_units;
	logic                 fine_point;
	logic                 bar_enable;
	logic                 done;
	logic [31:0]          display_word;
	logic                 out_of_range;
	logic [13:0]          distance_value;
	logic                 bar_write;
	logic [11:0]          bar_pattern;

	reading_t    pending_readings [$];
	int unsigned mismatches;
	int unsigned cycles;

	echo_ticks_to_seven_segment_top #(
		.TICK_BITS(TICK_BITS)
	) DUT (
		.clk(clk),
		.arst_n(arst_n),
		.start(start),
		.busy(busy),
		.echo_ticks(echo_ticks),
		.metre_units(metre_units),
		.fine_point(fine_point),
		.bar_enable(bar_enable),
		.done(done),
		.display_word(display_word),
		.out_of_range(out_of_range),
		.distance_value(distance_value),
		.bar_write(bar_write),
		.bar_pattern(bar_pattern)
	);

	initial begin
		clk = 1'b0;
		forever #1 clk = ~clk;
	end

	// Divisor applied to ticks * 34029: fine adds a factor of 10, metre 100
	function automatic longint unsigned mode_divisor(input logic metre, input logic fine);
		mode_t mode;
		mode = mode_t'({metre, fine});
		case (mode)
			MODE_PLAIN: return 64'd100000;
			MODE_FINE:  return 64'd1000000;
			MODE_METRE: return 64'd10000000;
			default:    return 64'd100000000;
		endcase
	endfunction

	// Exact distance, display word and bar step for one echo length
	function automatic reading_t predict_reading(input logic [TICK_BITS-1:0] ticks,
			input logic metre, input logic fine, input logic bar_on);
		reading_t        r;
		longint unsigned den;
		longint unsigned num;
		longint unsigned q;
		int unsigned     d;
		int unsigned     step;
		logic [7:0]      thou, hund, tens, unit;
		den = mode_divisor(metre, fine);
		num = 64'(ticks) * SCALE;
		q   = num / den;
		r.over = (q >= 64'(RANGE_LIMIT));
		d = r.over ? int'(RANGE_LIMIT) : int'(q);
		r.distance = d[13:0];
		if (r.over) begin
			r.word = ERROR_WORD;
		end else begin
			thou = DIGIT_SEG[(d / 1000) % 10];
			hund = DIGIT_SEG[(d / 100) % 10];
			tens = DIGIT_SEG[(d / 10) % 10];
			unit = DIGIT_SEG[d % 10];
			// lit point is an active-low bit 7
			if (fine)
				hund[7] = 1'b0;
			else
				thou[7] = 1'b0;
			r.word = {thou, hund, tens, unit};
		end
		r.bar_wr  = 1'b1;
		r.bar_pat = '0;
		if (bar_on) begin
			if (r.over) begin
				r.bar_wr = 1'b0;
			end else begin
				// first step whose upper bound the exact distance does not pass
				step = 1;
				while (step < 10 && num > 64'd1000 * 64'(step) * den)
					step++;
				r.bar_pat = (step == 10) ? BAR_TOP : 12'((13'd1 << (step - 1)) - 1);
			end
		end
		return r;
	endfunction

	// Smallest echo length whose truncated distance is at least the target
	function automatic logic [TICK_BITS-1:0] ticks_for(input int unsigned distance,
			input logic metre, input logic fine);
		longint unsigned t;
		t = (64'(distance) * mode_divisor(metre, fine) + SCALE - 1) / SCALE;
		return (t > TICKS_MAX) ? TICKS_MAX[TICK_BITS-1:0] : t[TICK_BITS-1:0];
	endfunction

	// Largest echo length still inside bar step k (k = 10 is the range limit)
	function automatic longint unsigned step_floor(input int unsigned k,
			input logic metre, input logic fine);
		return (64'd1000 * 64'(k) * mode_divisor(metre, fine)) / SCALE;
	endfunction

	task automatic report_mismatch(input string what, input logic [31:0] got,
			input logic [31:0] want);
		$display("[%0t] mismatch on %s: got %h, expected %h", $realtime, what, got, want);
		mismatches++;
	endtask

	// Raise start with one echo length and hold it until the transfer is taken
	task automatic send_echo(input logic [TICK_BITS-1:0] ticks, input logic metre,
			input logic fine, input logic bar_on);
		@(negedge clk);
		echo_ticks  <= ticks;
		metre_units <= metre;
		fine_point  <= fine;
		bar_enable  <= bar_on;
		start       <= 1'b1;
		do
			@(posedge clk);
		while (busy);
	endtask

	// Drop start for a gap of random length, now and then
	task automatic maybe_pause();
		int unsigned gap;
		if ($urandom_range(0, 3) == 0) begin
			gap = $urandom_range(1, 19);
			@(negedge clk);
			start <= 1'b0;
			repeat (gap - 1) @(negedge clk);
		end
	endtask

	task automatic send_near_step(input int unsigned k, input logic metre,
			input logic fine, input logic bar_on);
		longint unsigned t;
		t = step_floor(k, metre, fine);
		send_echo(t[TICK_BITS-1:0], metre, fine, bar_on);
		maybe_pause();
		send_echo(TICK_BITS'(t + 1), metre, fine, bar_on);
		maybe_pause();
	endtask

	// Zero echoes in every mode; full-scale echoes with the bar on and off
	task automatic test_zero_and_full_scale();
		for (int m = 0; m < 4; m++) begin
			send_echo('0, m[1], m[0], 1'b1);
			maybe_pause();
		end
		send_echo('1, 1'b0, 1'b0, 1'b1);
		send_echo('1, 1'b0, 1'b0, 1'b0);
		send_echo('1, 1'b1, 1'b1, 1'b1);
		maybe_pause();
	endtask

	// Every digit code appears, with the point on either digit
	task automatic test_digit_patterns();
		send_echo(ticks_for(9876, 1'b0, 1'b0), 1'b0, 1'b0, 1'b1);
		send_echo(ticks_for(5432, 1'b0, 1'b1), 1'b0, 1'b1, 1'b1);
		maybe_pause();
		send_echo(ticks_for(1098, 1'b1, 1'b0), 1'b1, 1'b0, 1'b0);
		send_echo(ticks_for(7654, 1'b1, 1'b1), 1'b1, 1'b1, 1'b1);
		send_echo(ticks_for(9999, 1'b0, 1'b0), 1'b0, 1'b0, 1'b1);
		maybe_pause();
	endtask

	// Either side of bar steps 1 and 9 and of the range limit
	task automatic test_bar_steps();
		send_near_step(1, 1'b0, 1'b1, 1'b1);
		send_near_step(9, 1'b0, 1'b0, 1'b1);
		send_near_step(10, 1'b0, 1'b0, 1'b1);
		send_near_step(10, 1'b1, 1'b0, 1'b1);
	endtask

	// Mix of full-range lengths, lengths aimed at a distance, and step edges
	task automatic test_random_echoes();
		logic [TICK_BITS-1:0] ticks;
		logic                 metre, fine, bar_on;
		int unsigned          pick;
		longint unsigned      t;
		for (int i = 0; i < RANDOM_ITEMS; i++) begin
			metre  = 1'($urandom_range(0, 1));
			fine   = 1'($urandom_range(0, 1));
			bar_on = 1'($urandom_range(0, 3) != 0);
			pick   = $urandom_range(0, 9);
			if (pick < 4) begin
				ticks = TICK_BITS'($urandom());
			end else if (pick < 8) begin
				ticks = ticks_for($urandom_range(0, 10100), metre, fine);
			end else begin
				t = step_floor($urandom_range(1, 10), metre, fine) + $urandom_range(0, 1);
				ticks = (t > TICKS_MAX) ? TICKS_MAX[TICK_BITS-1:0] : t[TICK_BITS-1:0];
			end
			send_echo(ticks, metre, fine, bar_on);
			// keep the closing stretch back-to-back
			if (i < RANDOM_ITEMS - CALM_ITEMS)
				maybe_pause();
		end
	endtask

	// Predict on each accepted transfer; check each done against the oldest
	always @(posedge clk) begin : reading_check
		reading_t want;
		if (arst_n && start && !busy)
			pending_readings.push_back(predict_reading(echo_ticks, metre_units,
					fine_point, bar_enable));
		if (done) begin
			if (pending_readings.size() == 0) begin
				report_mismatch("unexpected done", 32'(done), 32'd0);
			end else begin
				want = pending_readings.pop_front();
				if (display_word !== want.word)
					report_mismatch("display_word", display_word, want.word);
				if (out_of_range !== want.over)
					report_mismatch("out_of_range", 32'(out_of_range), 32'(want.over));
				if (distance_value !== want.distance)
					report_mismatch("distance_value", 32'(distance_value),
							32'(want.distance));
				if (bar_write !== want.bar_wr)
					report_mismatch("bar_write", 32'(bar_write), 32'(want.bar_wr));
				if (bar_pattern !== want.bar_pat)
					report_mismatch("bar_pattern", 32'(bar_pattern), 32'(want.bar_pat));
			end
		end
	end

	// Give up on a hung run
	always @(posedge clk) begin
		cycles++;
		if (cycles > LIMIT_CYCLES) begin
			$display("FAILURE");
			$finish;
		end
	end

	initial begin
		mismatches  = 0;
		cycles      = 0;
		arst_n      = 1'b0;
		start       = 1'b0;
		echo_ticks  = '0;
		metre_units = 1'b0;
		fine_point  = 1'b0;
		bar_enable  = 1'b0;
		repeat (8) @(negedge clk);
		arst_n = 1'b1;

		test_zero_and_full_scale();
		test_digit_patterns();
		test_bar_steps();
		test_random_echoes();

		@(negedge clk);
		start <= 1'b0;
		// drain the pipeline, then allow a few spare cycles for stray strobes
		while (pending_readings.size() != 0)
			@(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);

		if (mismatches == 0)
			$display("SUCCESS");
		else
			$display("FAILURE");
		$finish;
	end

endmodule
